// ----- hw/rtl/tccw_pkg.sv -----
package tccw_pkg;

    localparam int LINE_CELLS_DEF  = 80;
    localparam int VIEW_CELLS_DEF  = 2000;
    localparam int STORE_CELLS_DEF = 16384;

    localparam int CHAR_W  = 8;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 8;
    localparam int CELL_W  = 14;
    localparam int ATTR_W  = 8;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 64;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd7;
    localparam logic [ATTR_W-1:0] ATTR_NEWLINE = 8'd0;

    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_GOTO = 1'b1;

    localparam int CURSOR_RESET = 400;

    typedef struct packed {
        logic sub;
    } t_alu_ctl;

endpackage

// ----- hw/rtl/tccw_alu.sv -----
module tccw_alu #(
    parameter int W = 18
) (
    input  logic [W-1:0]       i_a,
    input  logic [W-1:0]       i_b,
    input  tccw_pkg::t_alu_ctl i_ctl,
    output logic [W-1:0]       o_res,
    output logic               o_ge
);
    import tccw_pkg::*;

    logic [W:0] sum;

    // a - b = a + ~b + 1; carry out set means a >= b
    assign sum   = {1'b0, i_a} + {1'b0, (i_ctl.sub ? ~i_b : i_b)} + {{W{1'b0}}, i_ctl.sub};
    assign o_res = sum[W-1:0];
    assign o_ge  = sum[W];

endmodule

// ----- hw/rtl/text_console_cursor_writer.sv -----
// Character-cell console writer.
// Slave stream: tuser = kind (0 put character, 1 cursor move), tdata = char_code,
// column, row. Master stream: one result per item, tuser = write_valid, tdata =
// write_cell, write_char, write_attr, cursor_index, view_start.
// Config: i_cfg_wr_en / i_cfg_wr_data load the attribute byte; write only while idle.
// One item at a time; all sums go through one shared adder.
// The block returns to idle as the result is loaded, and only then takes the next
// transfer. Each line scrolled passes the scroll states end, compare and advance;
// a cursor move reduces the column by repeated subtraction of LINE_CELLS, unless
// the cell is saturated at the store end.
// A transfer is accepted in idle; the result is loaded into an output register,
// so the next item is taken while the result still waits. If the receiver
// stalls with a result pending, the following item stops before its result
// load until the pending one is taken.
// Reset (synchronous, active low): cursor at cell 400, view at cell 0,
// attribute 7, no result pending.
module text_console_cursor_writer #(
    parameter int LINE_CELLS  = tccw_pkg::LINE_CELLS_DEF,
    parameter int VIEW_CELLS  = tccw_pkg::VIEW_CELLS_DEF,
    parameter int STORE_CELLS = tccw_pkg::STORE_CELLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [7:0] char_code, [14:8] column, [22:15] row
    input  logic [tccw_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // [0] kind
    input  logic                           i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [13:0] write_cell, [21:14] write_char, [29:22] write_attr,
    // [43:30] cursor_index, [57:44] view_start
    output logic [tccw_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // [0] write_valid
    output logic                           o_m_axis_tuser,
    input  logic                           i_cfg_wr_en,
    input  logic [tccw_pkg::ATTR_W-1:0]    i_cfg_wr_data
);
    import tccw_pkg::*;

    localparam int W = $clog2(STORE_CELLS + VIEW_CELLS + 256 * LINE_CELLS) + 1;

    localparam logic [W-1:0] K_LINE       = W'(LINE_CELLS);
    localparam logic [W-1:0] K_VIEW       = W'(VIEW_CELLS);
    localparam logic [W-1:0] K_STORE      = W'(STORE_CELLS);
    localparam logic [W-1:0] K_LAST       = W'(STORE_CELLS - 1);
    localparam logic [W-1:0] K_LAST_LINE  = W'(((STORE_CELLS - 1) / LINE_CELLS) * LINE_CELLS);
    localparam logic [W-1:0] K_NL_LIMIT   = W'(STORE_CELLS - LINE_CELLS);
    localparam logic [W-1:0] K_CUR_RST    = W'(CURSOR_RESET);
    localparam logic [W-1:0] K_LINE_RST   = W'((CURSOR_RESET / LINE_CELLS) * LINE_CELLS);
    localparam logic [W-1:0] K_ONE        = W'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_G_MUL, S_G_ADD, S_G_SAT, S_G_MOD, S_G_LINE,
        S_P_CHK, S_P_LINE, S_N_CHK, S_B_CHK, S_B_LINE,
        S_SC_END, S_SC_CMP, S_SC_ADV, S_DONE
    } t_state;

    t_state             r_state;
    logic               r_kind;
    logic [CHAR_W-1:0]  r_char;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [ATTR_W-1:0]  r_attr;
    logic [W-1:0]       r_cursor;
    logic [W-1:0]       r_line;
    logic [W-1:0]       r_view;
    logic [W-1:0]       r_acc;
    logic [W-1:0]       r_tmp;
    logic               r_wrap;
    logic               r_wr;
    logic [W-1:0]       r_wcell;
    logic [CHAR_W-1:0]  r_wchar;
    logic [ATTR_W-1:0]  r_wattr;
    logic               r_ovalid;
    logic               r_owr;
    logic [M_TDATA_W-1:0] r_odata;

    logic [W-1:0] alu_a;
    logic [W-1:0] alu_b;
    t_alu_ctl     alu_ctl;
    logic [W-1:0] alu_res;
    logic         alu_ge;
    logic         s_xfer;
    logic         m_xfer;

    tccw_alu #(.W(W)) u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_ctl (alu_ctl),
        .o_res (alu_res),
        .o_ge  (alu_ge)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_xfer          = i_s_axis_tvalid && o_s_axis_tready;
    assign m_xfer          = r_ovalid && i_m_axis_tready;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_owr;

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_ctl = '{sub: 1'b0};
        case (r_state)
            S_G_ADD:  begin alu_a = r_acc;       alu_b = W'(r_col); end
            S_G_MOD:  begin alu_a = W'(r_col);   alu_b = K_LINE;  alu_ctl.sub = 1'b1; end
            S_G_LINE: begin alu_a = r_tmp;       alu_b = W'(r_col); alu_ctl.sub = 1'b1; end
            S_P_CHK:  begin alu_a = r_cursor;    alu_b = K_ONE; end
            S_P_LINE: begin alu_a = r_cursor;    alu_b = r_line;  alu_ctl.sub = 1'b1; end
            S_N_CHK:  begin alu_a = r_line;      alu_b = K_LINE; end
            S_B_CHK:  begin alu_a = r_cursor;    alu_b = K_ONE;   alu_ctl.sub = 1'b1; end
            S_B_LINE: begin alu_a = r_line;      alu_b = K_LINE;  alu_ctl.sub = 1'b1; end
            S_SC_END: begin alu_a = r_view;      alu_b = K_VIEW; end
            S_SC_CMP: begin alu_a = r_cursor;    alu_b = r_tmp;   alu_ctl.sub = 1'b1; end
            S_SC_ADV: begin alu_a = r_view;      alu_b = K_LINE; end
            default:  begin alu_a = '0;          alu_b = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_attr   <= ATTR_RESET;
            r_cursor <= K_CUR_RST;
            r_line   <= K_LINE_RST;
            r_view   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_attr <= i_cfg_wr_data;
            end
            // in S_DONE a transfer always comes with the next result load
            if (m_xfer && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_xfer) begin
                        r_kind  <= i_s_axis_tuser;
                        r_char  <= i_s_axis_tdata[7:0];
                        r_col   <= i_s_axis_tdata[14:8];
                        r_row   <= i_s_axis_tdata[22:15];
                        r_wr    <= 1'b0;
                        r_wcell <= '0;
                        r_wchar <= '0;
                        r_wattr <= '0;
                        if (i_s_axis_tuser == KIND_GOTO) begin
                            r_state <= S_G_MUL;
                        end else if (i_s_axis_tdata[7:0] == CH_NEWLINE) begin
                            r_state <= S_N_CHK;
                        end else if (i_s_axis_tdata[7:0] == CH_BACKSPACE) begin
                            r_state <= S_B_CHK;
                        end else begin
                            r_state <= S_P_CHK;
                        end
                    end
                end
                S_G_MUL: begin
                    r_acc   <= W'(32'(r_row) * LINE_CELLS);
                    r_state <= S_G_ADD;
                end
                S_G_ADD: begin
                    r_tmp   <= alu_res;
                    r_state <= S_G_SAT;
                end
                S_G_SAT: begin
                    if (r_tmp > K_LAST) begin
                        r_cursor <= K_LAST;
                        r_line   <= K_LAST_LINE;
                        r_state  <= S_DONE;
                    end else begin
                        r_state  <= S_G_MOD;
                    end
                end
                S_G_MOD: begin
                    if (alu_ge) begin
                        r_col <= alu_res[COL_W-1:0];
                    end else begin
                        r_state <= S_G_LINE;
                    end
                end
                S_G_LINE: begin
                    r_line   <= alu_res;
                    r_cursor <= r_tmp;
                    r_state  <= S_DONE;
                end
                S_P_CHK: begin
                    if (r_cursor == K_LAST) begin
                        r_state <= S_SC_END;
                    end else begin
                        r_wr     <= 1'b1;
                        r_wcell  <= r_cursor;
                        r_wchar  <= r_char;
                        r_wattr  <= r_attr;
                        r_cursor <= alu_res;
                        r_state  <= S_P_LINE;
                    end
                end
                S_P_LINE: begin
                    if (alu_res == K_LINE) begin
                        r_line <= r_cursor;
                    end
                    r_state <= S_SC_END;
                end
                S_N_CHK: begin
                    if (r_cursor < K_NL_LIMIT) begin
                        r_wr     <= 1'b1;
                        r_wcell  <= r_cursor;
                        r_wchar  <= CH_NEWLINE;
                        r_wattr  <= ATTR_NEWLINE;
                        r_cursor <= alu_res;
                        r_line   <= alu_res;
                    end
                    r_state <= S_SC_END;
                end
                S_B_CHK: begin
                    if (r_cursor == '0) begin
                        r_state <= S_SC_END;
                    end else begin
                        r_wrap   <= (r_cursor == r_line);
                        r_cursor <= alu_res;
                        r_state  <= S_B_LINE;
                    end
                end
                S_B_LINE: begin
                    r_wr    <= 1'b1;
                    r_wcell <= r_cursor;
                    r_wchar <= CH_SPACE;
                    r_wattr <= r_attr;
                    if (r_wrap) begin
                        r_line <= alu_res;
                    end
                    r_state <= S_SC_END;
                end
                S_SC_END: begin
                    r_tmp   <= alu_res;
                    r_state <= S_SC_CMP;
                end
                S_SC_CMP: begin
                    if (alu_ge && (r_tmp < K_STORE)) begin
                        r_state <= S_SC_ADV;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_SC_ADV: begin
                    r_view  <= alu_res;
                    r_state <= S_SC_END;
                end
                S_DONE: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_owr    <= r_wr;
                        r_odata  <= {6'b0, r_view[CELL_W-1:0], r_cursor[CELL_W-1:0],
                                     r_wattr, r_wchar, r_wcell[CELL_W-1:0]};
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_cursor_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor < K_STORE)
        else $error("cursor outside text store");

    a_view_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_view < K_STORE)
        else $error("view start outside text store");

    a_line_tracks_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_line <= r_cursor) && (r_cursor - r_line < K_LINE)))
        else $error("line start out of step with cursor");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_owr) |-> (r_odata[29:0] == '0))
        else $error("write fields set without a write");

    a_kind_goto_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && (r_kind == KIND_GOTO)) |-> !r_wr)
        else $error("cursor move issued a write");

endmodule

// ----- test/text_console_cursor_writer_chk.sv -----
module text_console_cursor_writer_chk #(
    parameter int LINE_CELLS  = tccw_pkg::LINE_CELLS_DEF,
    parameter int VIEW_CELLS  = tccw_pkg::VIEW_CELLS_DEF,
    parameter int STORE_CELLS = tccw_pkg::STORE_CELLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [tccw_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                           i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [tccw_pkg::M_TDATA_W-1:0] i_m_tdata,
    input  logic                           i_m_tuser,
    input  logic                           i_cfg_wr_en,
    input  logic [tccw_pkg::ATTR_W-1:0]    i_cfg_wr_data,
    output int                             o_errors,
    output int                             o_pending
);
    import tccw_pkg::*;

    localparam int S_COL_LSB    = CHAR_W;
    localparam int S_ROW_LSB    = CHAR_W + COL_W;
    localparam int M_CODE_LSB   = CELL_W;
    localparam int M_ATTR_LSB   = CELL_W + CHAR_W;
    localparam int M_CURSOR_LSB = CELL_W + CHAR_W + ATTR_W;
    localparam int M_VIEW_LSB   = 2 * CELL_W + CHAR_W + ATTR_W;

    typedef struct packed {
        logic              valid;
        logic [CELL_W-1:0] wcell;
        logic [CHAR_W-1:0] code;
        logic [ATTR_W-1:0] attr;
        logic [CELL_W-1:0] cursor;
        logic [CELL_W-1:0] view;
    } t_console_write;

    t_console_write    pending_writes[$];
    logic [ATTR_W-1:0] attr_q;
    int unsigned       cursor_q;
    int unsigned       view_q;
    int                err_cnt;

    function automatic t_console_write predict_write(input logic kind,
                                                     input logic [S_TDATA_W-1:0] d);
        t_console_write    r;
        logic [CHAR_W-1:0] ch;
        int unsigned       pos;
        r  = '0;
        ch = d[CHAR_W-1:0];
        if (kind == KIND_GOTO) begin
            pos = d[S_ROW_LSB +: ROW_W] * LINE_CELLS + d[S_COL_LSB +: COL_W];
            if (pos > STORE_CELLS - 1)
                pos = STORE_CELLS - 1;
            cursor_q = pos;
        end else begin
            if (ch == CH_NEWLINE) begin
                if (cursor_q < STORE_CELLS - LINE_CELLS) begin
                    r.valid  = 1'b1;
                    r.wcell  = CELL_W'(cursor_q);
                    r.code   = CH_NEWLINE;
                    r.attr   = ATTR_NEWLINE;
                    cursor_q = LINE_CELLS * (cursor_q / LINE_CELLS + 1);
                end
            end else if (ch == CH_BACKSPACE) begin
                if (cursor_q > 0) begin
                    cursor_q = cursor_q - 1;
                    r.valid  = 1'b1;
                    r.wcell  = CELL_W'(cursor_q);
                    r.code   = CH_SPACE;
                    r.attr   = attr_q;
                end
            end else begin
                if (cursor_q < STORE_CELLS - 1) begin
                    r.valid  = 1'b1;
                    r.wcell  = CELL_W'(cursor_q);
                    r.code   = ch;
                    r.attr   = attr_q;
                    cursor_q = cursor_q + 1;
                end
            end
            // scroll by whole lines, only while the view end still lies inside the store
            while (cursor_q >= view_q + VIEW_CELLS && view_q + VIEW_CELLS < STORE_CELLS)
                view_q = view_q + LINE_CELLS;
        end
        r.cursor = CELL_W'(cursor_q);
        r.view   = CELL_W'(view_q);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            err_cnt++;
        end
    endtask

    task automatic check_write(input logic [M_TDATA_W-1:0] d, input logic wr);
        t_console_write e;
        if (pending_writes.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, got tuser %0d tdata %h",
                     $time, wr, d);
            err_cnt++;
        end else begin
            e = pending_writes.pop_front();
            check_field("write_valid", 32'(e.valid), 32'(wr));
            check_field("write_cell", 32'(e.wcell), 32'(d[0 +: CELL_W]));
            check_field("write_char", 32'(e.code), 32'(d[M_CODE_LSB +: CHAR_W]));
            check_field("write_attr", 32'(e.attr), 32'(d[M_ATTR_LSB +: ATTR_W]));
            check_field("cursor_index", 32'(e.cursor), 32'(d[M_CURSOR_LSB +: CELL_W]));
            check_field("view_start", 32'(e.view), 32'(d[M_VIEW_LSB +: CELL_W]));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            attr_q   = ATTR_RESET;
            cursor_q = CURSOR_RESET;
            view_q   = 0;
            err_cnt  = 0;
            pending_writes.delete();
        end else begin
            if (i_m_tvalid && i_m_tready)
                check_write(i_m_tdata, i_m_tuser);
            if (i_s_tvalid && i_s_tready)
                pending_writes.push_back(predict_write(i_s_tuser, i_s_tdata));
            if (i_cfg_wr_en)
                attr_q = i_cfg_wr_data;
        end
        o_errors  <= err_cnt;
        o_pending <= pending_writes.size();
    end

endmodule

// ----- test/text_console_cursor_writer_tb.sv -----
module text_console_cursor_writer_tb;
    import tccw_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT_ITEM = 1000;
    localparam int RAND_ITEMS   = 400;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 s_tuser     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_wr_en   = 1'b0;
    logic [ATTR_W-1:0]    cfg_wr_data = '0;

    int errors;
    int pending;
    int items_in     = 0;
    int quiet_cycles = 0;
    int snd_idle_pct = 19;
    int rcv_idle_pct = 49;
    bit hold_done    = 1'b0;

    text_console_cursor_writer u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data)
    );

    text_console_cursor_writer_chk u_chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        if (s_tvalid && s_tready)
            items_in <= items_in + 1;
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** text_console_cursor_writer: FAILED **");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off so the block backs up
    initial begin
        forever begin
            @(posedge clk);
            if (!hold_done && items_in >= HOLD_AT_ITEM) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                m_tready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    task automatic send_item(input logic kind, input logic [CHAR_W-1:0] ch,
                             input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
        if ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < snd_idle_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, row, col, ch};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] ch);
        send_item(KIND_PUT, ch, COL_W'($urandom_range(127)), ROW_W'($urandom_range(255)));
    endtask

    task automatic goto_cell(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
        send_item(KIND_GOTO, CHAR_W'($urandom_range(255)), col, row);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic write_attr(input logic [ATTR_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_item(input int row_hi);
        int sel;
        int col;
        int row;
        sel = $urandom_range(99);
        if (sel < 15) begin
            col = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(79);
            row = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(row_hi);
            goto_cell(COL_W'(col), ROW_W'(row));
        end else if (sel < 27) begin
            put_char(CH_NEWLINE);
        end else if (sel < 37) begin
            put_char(CH_BACKSPACE);
        end else begin
            put_char(CHAR_W'($urandom_range(255)));
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // near the top of the store
        write_attr(8'hFF);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h41);
        put_char(CH_NEWLINE);
        put_char(CH_BACKSPACE);
        put_char(CH_BACKSPACE);
        goto_cell(7'd0, 8'd0);
        put_char(CH_BACKSPACE);
        put_char(8'h7F);
        goto_cell(7'd127, 8'd0);
        put_char(CH_NEWLINE);
        goto_cell(7'd79, 8'd24);
        put_char(8'h78);
        put_char(CH_NEWLINE);
        goto_cell(7'd0, 8'd1);

        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i == RAND_ITEMS / 2)
                drain();
            random_item((i < 200) ? 5 + i : 204);
        end

        // store end
        drain();
        write_attr(8'h00);
        goto_cell(7'd79, 8'd204);
        put_char(8'h55);
        put_char(CH_NEWLINE);
        goto_cell(7'd0, 8'd204);
        put_char(CH_NEWLINE);
        put_char(8'h5A);
        goto_cell(7'd127, 8'd255);
        goto_cell(7'd0, 8'd0);
        put_char(CH_BACKSPACE);
        put_char(CH_NEWLINE);

        drain();
        write_attr(ATTR_W'($urandom_range(255)));
        snd_idle_pct = 49;
        rcv_idle_pct = 19;
        for (int i = 0; i < RAND_ITEMS; i++)
            random_item(204);

        drain();
        write_attr(8'hA5);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        for (int i = 0; i < RAND_ITEMS; i++)
            random_item(204);

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("** text_console_cursor_writer: PASSED **");
        else
            $display("** text_console_cursor_writer: FAILED **");
        $finish;
    end

endmodule
